>>> rtl/hcfp_pkg.sv
// Package: constants, status codes and shared types of the hex CAN frame parser.
package hcfp_pkg;

	localparam int MAX_DATA_BYTES = 8;
	localparam int ID_DIGITS      = 3;
	localparam int DATA_START     = ID_DIGITS + 1;
	localparam int MIN_LEN        = DATA_START + 2;
	localparam int MAX_LEN        = DATA_START + 2 * MAX_DATA_BYTES;
	localparam int CNT_W          = 5;
	localparam int COUNT_MAX      = (1 << CNT_W) - 1;
	localparam int ID_W           = 4 * ID_DIGITS;
	localparam int DATA_W         = 64;
	localparam int BCNT_W         = 4;

	localparam logic [7:0] CHR_SPACE   = 8'h20;
	localparam logic [7:0] CHR_ZERO    = 8'h30;
	localparam logic [7:0] CHR_NINE    = 8'h39;
	localparam logic [7:0] CHR_UPPER_A = 8'h41;
	localparam logic [7:0] CHR_UPPER_F = 8'h46;
	localparam logic [7:0] CHR_LOWER_A = 8'h61;
	localparam logic [7:0] CHR_LOWER_F = 8'h66;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_SHORT    = 2'd1,
		STAT_NO_SPACE = 2'd2,
		STAT_TOO_LONG = 2'd3
	} status_t;

	// One decoded character held in the input stage.
	typedef struct packed {
		logic       valid;
		logic       last;
		logic       is_space;
		logic       bad;
		logic [3:0] nib;
	} dchar_t;

endpackage

>>> rtl/hcfp_if.sv
// Interfaces: character input channel and frame result channel.
interface hcfp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface hcfp_frame_if;
	logic        valid;
	logic        ready;
	logic [11:0] frame_id;
	logic [3:0]  byte_count;
	logic [63:0] frame_data;
	logic [1:0]  status;
	logic        bad_digit;

	modport source (output valid, output frame_id, output byte_count, output frame_data,
		output status, output bad_digit, input ready);
	modport sink (input valid, input frame_id, input byte_count, input frame_data,
		input status, input bad_digit, output ready);
endinterface

>>> rtl/hcfp_char_dec.sv
// Input stage: hex decode of the incoming character and the stage-1 register.
module hcfp_char_dec (
	input  logic              clk,
	input  logic              arst_n,
	hcfp_char_if.sink         chars,
	input  logic              take,
	output hcfp_pkg::dchar_t  dchar_s1
);
	import hcfp_pkg::*;

	logic [7:0] c;
	logic [7:0] d_num;
	logic [7:0] d_up;
	logic [7:0] d_lo;
	dchar_t     dec;
	logic       accept;

	assign c     = chars.char_code;
	assign d_num = c - CHR_ZERO;
	assign d_up  = c - CHR_UPPER_A;
	assign d_lo  = c - CHR_LOWER_A;

	always_comb begin
		dec          = '0;
		dec.valid    = 1'b1;
		dec.last     = chars.last_char;
		dec.is_space = (c == CHR_SPACE);
		if (c >= CHR_ZERO && c <= CHR_NINE) begin
			dec.nib = d_num[3:0];
		end else if (c >= CHR_UPPER_A && c <= CHR_UPPER_F) begin
			dec.nib = d_up[3:0] + 4'd10;
		end else if (c >= CHR_LOWER_A && c <= CHR_LOWER_F) begin
			dec.nib = d_lo[3:0] + 4'd10;
		end else begin
			dec.bad = 1'b1;
		end
	end

	// Take a new item whenever the register is empty or the held one moves on this cycle.
	assign chars.ready = !dchar_s1.valid || take;
	assign accept      = chars.valid && chars.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dchar_s1 <= '0;
		end else if (accept) begin
			dchar_s1 <= dec;
		end else if (take) begin
			dchar_s1.valid <= 1'b0;
		end
	end

endmodule

>>> rtl/hcfp_frame_asm.sv
// Frame assembly: running message state, frame checks and the result register.
module hcfp_frame_asm (
	input  logic             clk,
	input  logic             arst_n,
	input  hcfp_pkg::dchar_t dchar_s1,
	output logic             take,
	hcfp_frame_if.source     frames
);
	import hcfp_pkg::*;

	localparam int BIDX_W = CNT_W - 1;

	logic [CNT_W-1:0]  cnt_q, cnt_n;
	logic [ID_W-1:0]   id_q, id_n;
	logic              space_q, space_n;
	logic [3:0]        hi_q, hi_n;
	logic              pend_bad_q, pend_bad_n;
	logic [DATA_W-1:0] data_q, data_n;
	logic              id_bad_q, id_bad_n;
	logic              data_bad_q, data_bad_n;

	logic [CNT_W-1:0]  k;
	logic [BIDX_W-1:0] bidx;
	logic [CNT_W-1:0]  dlen;
	logic              out_free;

	logic [ID_W-1:0]   r_id;
	logic [BCNT_W-1:0] r_bcnt;
	logic [DATA_W-1:0] r_data;
	status_t           r_stat;
	logic              r_bad;

	assign out_free = !frames.valid || frames.ready;
	assign take     = dchar_s1.valid && (!dchar_s1.last || out_free);

	assign k    = cnt_q - CNT_W'(DATA_START);
	assign bidx = k[CNT_W-1:1];

	always_comb begin
		id_n       = id_q;
		space_n    = space_q;
		hi_n       = hi_q;
		pend_bad_n = pend_bad_q;
		data_n     = data_q;
		id_bad_n   = id_bad_q;
		data_bad_n = data_bad_q;
		if (cnt_q < CNT_W'(ID_DIGITS)) begin
			id_n     = {id_q[ID_W-5:0], dchar_s1.nib};
			id_bad_n = id_bad_q | dchar_s1.bad;
		end else if (cnt_q == CNT_W'(ID_DIGITS)) begin
			space_n = dchar_s1.is_space;
		end else if (cnt_q < CNT_W'(MAX_LEN)) begin
			if (!k[0]) begin
				hi_n       = dchar_s1.nib;
				pend_bad_n = dchar_s1.bad;
			end else begin
				for (int lane = 0; lane < MAX_DATA_BYTES; lane++) begin
					if (bidx == BIDX_W'(lane)) begin
						data_n[lane*8 +: 8] = data_q[lane*8 +: 8] | {hi_q, dchar_s1.nib};
					end
				end
				data_bad_n = data_bad_q | pend_bad_q | dchar_s1.bad;
			end
		end
		// Saturate the count.
		cnt_n = (cnt_q == CNT_W'(COUNT_MAX)) ? cnt_q : cnt_q + 1'b1;
	end

	assign dlen = cnt_n - CNT_W'(DATA_START);

	always_comb begin
		r_id   = '0;
		r_bcnt = '0;
		r_data = '0;
		r_stat = STAT_OK;
		r_bad  = 1'b0;
		if (cnt_n < CNT_W'(MIN_LEN)) begin
			r_stat = STAT_SHORT;
		end else begin
			r_id  = id_n;
			r_bad = id_bad_n;
			if (!space_n) begin
				r_stat = STAT_NO_SPACE;
			end else if (cnt_n > CNT_W'(MAX_LEN)) begin
				r_stat = STAT_TOO_LONG;
			end else begin
				r_bcnt = dlen[BCNT_W:1];
				r_data = data_n;
				r_bad  = id_bad_n | data_bad_n;
			end
		end
	end

	// Running state: advance on each item, clear after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			id_q       <= '0;
			space_q    <= 1'b0;
			hi_q       <= '0;
			pend_bad_q <= 1'b0;
			data_q     <= '0;
			id_bad_q   <= 1'b0;
			data_bad_q <= 1'b0;
		end else if (take) begin
			if (dchar_s1.last) begin
				cnt_q      <= '0;
				id_q       <= '0;
				space_q    <= 1'b0;
				hi_q       <= '0;
				pend_bad_q <= 1'b0;
				data_q     <= '0;
				id_bad_q   <= 1'b0;
				data_bad_q <= 1'b0;
			end else begin
				cnt_q      <= cnt_n;
				id_q       <= id_n;
				space_q    <= space_n;
				hi_q       <= hi_n;
				pend_bad_q <= pend_bad_n;
				data_q     <= data_n;
				id_bad_q   <= id_bad_n;
				data_bad_q <= data_bad_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames.valid <= 1'b0;
		end else if (take && dchar_s1.last) begin
			frames.valid <= 1'b1;
		end else if (frames.ready) begin
			frames.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && dchar_s1.last) begin
			frames.frame_id   <= r_id;
			frames.byte_count <= r_bcnt;
			frames.frame_data <= r_data;
			frames.status     <= r_stat;
			frames.bad_digit  <= r_bad;
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		take && dchar_s1.last |=> cnt_q == '0 && data_q == '0 && id_q == '0)
		else $error("state not cleared after last item");

	a_short_empty: assert property (@(posedge clk) disable iff (!arst_n)
		frames.valid && frames.status == STAT_SHORT |->
		frames.frame_id == '0 && frames.frame_data == '0 && !frames.bad_digit)
		else $error("short frame carries data");

	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		frames.valid && frames.status == STAT_OK |->
		frames.byte_count >= BCNT_W'(1) && frames.byte_count <= BCNT_W'(MAX_DATA_BYTES))
		else $error("byte count out of range");

	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		frames.valid && frames.status != STAT_OK |->
		frames.byte_count == '0 && frames.frame_data == '0)
		else $error("error frame carries data");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		dchar_s1.valid && dchar_s1.last && !out_free |=> dchar_s1.valid && $stable(cnt_q))
		else $error("last item lost while result stalled");

endmodule

>>> rtl/ascii_hex_can_frame_parser.sv
// Top level: ASCII hex CAN frame text parser.
//
//   channel  dir  payload                                                   item
//   chars    in   char_code[7:0], last_char                                 one character
//   frames   out  frame_id[11:0], byte_count[3:0], frame_data[63:0],
//                 status[1:0], bad_digit                                    one frame
//
// One character per cycle while no last character waits on a stalled frame. A character
// is decoded into the stage-1 register and from there updates the message state; the
// frame is loaded into the output register when its last character leaves the stage-1
// register. arst_n clears the count, message state and both valid flags.
// A stalled frame holds in the output register; only a last character waiting behind
// it stops the input, other characters keep flowing.
module ascii_hex_can_frame_parser (
	input  logic          clk,
	input  logic          arst_n,
	hcfp_char_if.sink     chars,
	hcfp_frame_if.source  frames
);
	import hcfp_pkg::*;

	dchar_t dchar_s1;
	logic   take;

	hcfp_char_dec u_dec (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.take     (take),
		.dchar_s1 (dchar_s1)
	);

	hcfp_frame_asm u_asm (
		.clk      (clk),
		.arst_n   (arst_n),
		.dchar_s1 (dchar_s1),
		.take     (take),
		.frames   (frames)
	);

endmodule
